// ----- src/lfu_page_replacement_defines.svh -----
// Assertion macros for the least-frequently-used replacement block.
// Depends on nothing; included by lfu_page_replacement, the file that carries assertions.
`ifndef LFU_PAGE_REPLACEMENT_DEFINES_SVH
`define LFU_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define LFU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define LFU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LFU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LFU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/lfu_pkg.sv -----
// Shared constants and types of the least-frequently-used replacement block.
// Depends on nothing; used by lfu_cell and lfu_page_replacement.
package lfu_pkg;

    localparam int unsigned PAGE_W         = 6;
    localparam int unsigned PAGE_SPAN      = 64;
    localparam int unsigned CFG_W          = 3;
    localparam int unsigned COUNT_W        = 16;
    localparam int unsigned STAMP_W        = 32;
    localparam int unsigned IDX_W          = 6;   // covers the largest frame table
    localparam int unsigned FRAME_OUT_W    = 2;
    localparam int unsigned FRAMES_DEF     = 4;
    localparam int unsigned PAGE_COUNT_DEF = 64;

    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(4);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    // Search word that walks along the row of frame cells.
    typedef struct packed {
        logic               vld;
        logic [PAGE_W-1:0]  page;
        logic               found;
        logic [IDX_W-1:0]   found_idx;
        logic               empty_found;
        logic [IDX_W-1:0]   empty_idx;
        logic [IDX_W-1:0]   best_idx;
        logic [PAGE_W-1:0]  best_page;
        logic [COUNT_W-1:0] best_count;
        logic [STAMP_W-1:0] best_stamp;
    } t_token;

    // Update broadcast to every cell once the decision is made.
    typedef struct packed {
        logic               en;
        logic               hit;
        logic [IDX_W-1:0]   idx;
        logic [PAGE_W-1:0]  page;
        logic [STAMP_W-1:0] stamp;
    } t_upd;

endpackage

// ----- src/lfu_cell.sv -----
// One frame of the replacement table: holds the frame's state and folds it
// into the search word passing by. Depends on lfu_pkg.
module lfu_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [lfu_pkg::CFG_W-1:0] i_limit,
    input  lfu_pkg::t_token          i_tok,
    input  lfu_pkg::t_upd            i_upd,
    output lfu_pkg::t_token          o_tok
);
    import lfu_pkg::*;

    localparam logic [IDX_W-1:0] IDX_V = IDX_W'(IDX);
    localparam bit               FIRST = (IDX == 0);

    logic               r_valid;
    logic [PAGE_W-1:0]  r_page;
    logic [COUNT_W-1:0] r_count;
    logic [STAMP_W-1:0] r_stamp;
    t_token             r_tok;
    t_token             n_tok;
    logic               in_use;
    logic               better;
    logic               sel;

    assign in_use = IDX_V < IDX_W'(i_limit);
    assign sel    = i_upd.en && (i_upd.idx == IDX_V);

    // Lower count wins; on equal counts the older reference wins.
    assign better = (r_count < i_tok.best_count) ||
                    ((r_count == i_tok.best_count) && (r_stamp < i_tok.best_stamp));

    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && in_use) begin
            if (!i_tok.found) begin
                if (r_valid && (r_page == i_tok.page)) begin
                    n_tok.found     = 1'b1;
                    n_tok.found_idx = IDX_V;
                end else if (!r_valid && !i_tok.empty_found) begin
                    n_tok.empty_found = 1'b1;
                    n_tok.empty_idx   = IDX_V;
                end
            end
            if (FIRST || better) begin
                n_tok.best_idx   = IDX_V;
                n_tok.best_page  = r_page;
                n_tok.best_count = r_count;
                n_tok.best_stamp = r_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
            r_stamp <= '0;
        end else if (sel) begin
            r_stamp <= i_upd.stamp;
            if (i_upd.hit) begin
                if (r_count != COUNT_MAX) begin
                    r_count <= r_count + COUNT_ONE;
                end
            end else begin
                r_valid <= 1'b1;
                r_count <= COUNT_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel && !i_upd.hit) begin
            r_page <= i_upd.page;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- src/lfu_page_replacement.sv -----
// Top level of the least-frequently-used page replacement block.
// Depends on lfu_pkg, lfu_cell and lfu_page_replacement_defines.svh.
//
//  Channel   Direction  Handshake                 Payload
//  command   in         start while !busy         i_page
//  result    out        o_valid, one-cycle strobe o_hit, o_frame_index,
//                                                 o_evicted_valid, o_evicted_page
//  config    in         i_cfg_we                  i_cfg_wdata (frames in use)
//
// The search word is registered in each frame cell in turn, in the first cell at
// the acceptance edge, and the edge after the last cell updates the table, loads
// the result and raises the result strobe. busy falls with the strobe, so the
// next word may be accepted at the edge that ends the strobe cycle.
// Reset is synchronous and active low; it empties every frame, clears the
// reference clock and sets the frame limit to four.
// The receiver cannot stall: each result word is shown for exactly one cycle.
`include "lfu_page_replacement_defines.svh"

module lfu_page_replacement #(
    parameter int unsigned FRAMES     = lfu_pkg::FRAMES_DEF,
    parameter int unsigned PAGE_COUNT = lfu_pkg::PAGE_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [lfu_pkg::PAGE_W-1:0]      i_page,
    input  logic                            i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]       i_cfg_wdata,
    output logic                            o_valid,
    output logic                            o_hit,
    output logic [lfu_pkg::FRAME_OUT_W-1:0] o_frame_index,
    output logic                            o_evicted_valid,
    output logic [lfu_pkg::PAGE_W-1:0]      o_evicted_page
);
    import lfu_pkg::*;

    // The limit register is three bits wide, so no more than seven frames
    // can ever be in use, however large the table is built.
    localparam int unsigned FRAMES_CAP = (FRAMES > 7) ? 7 : FRAMES;

    logic [CFG_W-1:0]   r_cfg;
    logic [CFG_W-1:0]   limit;
    logic               r_busy;
    logic [STAMP_W-1:0] r_clock;
    logic               r_valid;
    logic               r_hit;
    logic [FRAME_OUT_W-1:0] r_idx;
    logic               r_ev_valid;
    logic [PAGE_W-1:0]  r_ev_page;
    logic               accept;
    logic               evict;
    logic [PAGE_W-1:0]  wrap_lut [PAGE_SPAN];
    t_token             head;
    t_token             tok [FRAMES+1];
    t_token             tail;
    t_upd               upd;
    logic [FRAMES-1:0]  tok_vld;

    assign accept = start && !r_busy;

    // Pages wrap modulo the page count. The input is only six bits wide, so
    // the reduction is a constant table worked out at elaboration.
    for (genvar g = 0; g < PAGE_SPAN; g++) begin : g_wrap
        assign wrap_lut[g] = PAGE_W'(g % PAGE_COUNT);
    end

    // A limit of zero behaves as one frame; anything beyond the table
    // behaves as the whole table.
    always_comb begin
        if (r_cfg == '0) begin
            limit = CFG_W'(1);
        end else if (r_cfg > CFG_W'(FRAMES_CAP)) begin
            limit = CFG_W'(FRAMES_CAP);
        end else begin
            limit = r_cfg;
        end
    end

    // The search word enters the first cell at the acceptance edge.
    always_comb begin
        head      = '0;
        head.vld  = accept;
        head.page = wrap_lut[i_page];
    end

    assign tok[0] = head;

    // The row of frame cells. Each cell registers the word it passes on, so the
    // word passes through one register per cell on its way to the end of the row.
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        lfu_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_limit (limit),
            .i_tok   (tok[g]),
            .i_upd   (upd),
            .o_tok   (tok[g+1])
        );
        assign tok_vld[g] = tok[g+1].vld;
    end

    assign tail = tok[FRAMES];

    // Decision: a hit takes its own frame, otherwise the first empty frame,
    // otherwise the least frequently used frame picked along the row.
    assign evict = !tail.found && !tail.empty_found;

    always_comb begin
        upd       = '0;
        upd.en    = tail.vld;
        upd.hit   = tail.found;
        upd.page  = tail.page;
        upd.stamp = r_clock;
        if (tail.found) begin
            upd.idx = tail.found_idx;
        end else if (tail.empty_found) begin
            upd.idx = tail.empty_idx;
        end else begin
            upd.idx = tail.best_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= CFG_RESET;
            r_busy  <= 1'b0;
            r_clock <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (tail.vld) begin
                r_busy <= 1'b0;
            end
            // The reference clock stamps each word and then advances,
            // holding once it reaches its largest value.
            if (tail.vld && (r_clock != STAMP_MAX)) begin
                r_clock <= r_clock + STAMP_W'(1);
            end
            r_valid <= tail.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail.vld) begin
            r_hit      <= tail.found;
            r_idx      <= upd.idx[FRAME_OUT_W-1:0];
            r_ev_valid <= evict;
            r_ev_page  <= evict ? tail.best_page : '0;
        end
    end

    assign busy            = r_busy;
    assign o_valid         = r_valid;
    assign o_hit           = r_hit;
    assign o_frame_index   = r_idx;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;

    // Exactly one search word is in the row while the block is busy.
    `LFU_ASSERT_IMP(a_one_word, i_clk, i_rst_n, r_busy, $onehot(tok_vld), "busy without one word")
    // No word is in the row while the block is idle.
    `LFU_ASSERT_IMP(a_idle_empty, i_clk, i_rst_n, !r_busy, tok_vld == '0, "word in idle row")
    // An accepted word makes the block busy in the following cycle.
    `LFU_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, accept, r_busy, "accept did not set busy")
    // A hit never reports an eviction.
    `LFU_ASSERT_IMP(a_hit_no_evict, i_clk, i_rst_n, r_valid && r_hit, !r_ev_valid, "hit evicted")

endmodule
